### rtl/host_command_frame_builder_defines.svh
// assertion macros for the host command frame builder
// depends on nothing; used by the top level only
`ifndef HOST_COMMAND_FRAME_BUILDER_DEFINES_SVH
`define HOST_COMMAND_FRAME_BUILDER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HCFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hcfb_pkg.sv
// shared types and constants of the host command frame builder
// no dependencies
package hcfb_pkg;

  localparam logic [7:0] PREAMBLE_BYTE  = 8'h00;
  localparam logic [7:0] START_CODE_A   = 8'h00;
  localparam logic [7:0] START_CODE_B   = 8'hFF;
  localparam logic [7:0] POSTAMBLE_BYTE = 8'h00;
  localparam logic [7:0] TFI_RESET      = 8'd212;

  localparam logic       OP_START = 1'b0;
  localparam logic       OP_DATA  = 1'b1;

  // step numbers within one job
  localparam logic [3:0] STEP_PRE   = 4'd0;
  localparam logic [3:0] STEP_SCA   = 4'd1;
  localparam logic [3:0] STEP_SCB   = 4'd2;
  localparam logic [3:0] STEP_LEN   = 4'd3;
  localparam logic [3:0] STEP_LCS   = 4'd4;
  localparam logic [3:0] STEP_TFI   = 4'd5;
  localparam logic [3:0] STEP_CMD   = 4'd6;
  localparam logic [3:0] STEP_DCS   = 4'd7;
  localparam logic [3:0] STEP_POST  = 4'd8;
  localparam logic [3:0] STEP_LIMIT = 4'd9;   // most bytes one item can cause

  typedef enum logic [1:0] {
    JOB_HDR,
    JOB_HDR_TRL,
    JOB_DATA,
    JOB_DATA_TRL
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] len_byte;
    logic [7:0] lcs;
    logic [7:0] tfi;
    logic [7:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] dcs;
  } job_t;

  typedef struct packed {
    logic frame_open;
    logic rem_zero;
  } ctrl_stat_t;

  typedef struct packed {
    logic       job_valid;
    logic       last_step;
    logic [3:0] step;
  } emit_stat_t;

endpackage

### rtl/hcfb_frame_ctrl.sv
// frame state: TFI register, open flag, bytes remaining and running sum
// builds one job per accepted item, none for payload outside a frame; depends on hcfb_pkg
module hcfb_frame_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  input  logic                  in_accept,
  input  logic                  in_opcode,
  input  logic [7:0]            in_command_code,
  input  logic [7:0]            in_payload_length,
  input  logic [7:0]            in_payload_byte,
  output logic                  job_load,
  output hcfb_pkg::job_t        job,
  output hcfb_pkg::ctrl_stat_t  stat
);

  logic [7:0] tfi_r;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       open_r, open_nxt;
  logic [7:0] len_plus2;
  logic [7:0] hdr_sum;
  logic [7:0] acc_sum;
  logic [7:0] rem_dec;

  always_comb begin
    len_plus2 = in_payload_length + 8'd2;
    hdr_sum   = tfi_r + in_command_code;
    acc_sum   = sum_r + in_payload_byte;
    rem_dec   = rem_r - 8'd1;

    rem_nxt  = rem_r;
    sum_nxt  = sum_r;
    open_nxt = open_r;
    job_load = 1'b0;

    job.kind      = hcfb_pkg::JOB_HDR;
    job.len_byte  = len_plus2;
    job.lcs       = 8'd0 - len_plus2;
    job.tfi       = tfi_r;
    job.cmd       = in_command_code;
    job.data_byte = in_payload_byte;
    job.dcs       = 8'd0 - hdr_sum;

    if (in_accept) begin
      if (in_opcode == hcfb_pkg::OP_START) begin
        // a start abandons any open frame
        job_load = 1'b1;
        sum_nxt  = hdr_sum;
        if (in_payload_length == 8'd0) begin
          job.kind = hcfb_pkg::JOB_HDR_TRL;
          rem_nxt  = 8'd0;
          open_nxt = 1'b0;
        end else begin
          job.kind = hcfb_pkg::JOB_HDR;
          rem_nxt  = in_payload_length;
          open_nxt = 1'b1;
        end
      end else if (open_r) begin
        job_load = 1'b1;
        sum_nxt  = acc_sum;
        job.dcs  = 8'd0 - acc_sum;
        if (rem_dec == 8'd0) begin
          job.kind = hcfb_pkg::JOB_DATA_TRL;
          rem_nxt  = 8'd0;
          open_nxt = 1'b0;
        end else begin
          job.kind = hcfb_pkg::JOB_DATA;
          rem_nxt  = rem_dec;
        end
      end
      // data outside a frame is dropped
    end

    stat.frame_open = open_r;
    stat.rem_zero   = (rem_r == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tfi_r  <= hcfb_pkg::TFI_RESET;
      rem_r  <= 8'd0;
      sum_r  <= 8'd0;
      open_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tfi_r <= cfg_wr_data;
      end
      rem_r  <= rem_nxt;
      sum_r  <= sum_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

### rtl/hcfb_byte_emit.sv
// job register and byte sequencer feeding the registered result port
// depends on hcfb_pkg
module hcfb_byte_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_load,
  input  hcfb_pkg::job_t        job_in,
  output logic                  job_ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_frame_byte,
  output logic                  out_run_last,
  output logic                  out_frame_end,
  output hcfb_pkg::emit_stat_t  stat
);

  logic           job_valid_r, job_valid_nxt;
  hcfb_pkg::job_t job_r, job_nxt;
  logic [3:0]     step_r, step_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     byte_r;
  logic           run_last_r;
  logic           frame_end_r;

  logic           out_free;
  logic           advance;
  logic           last;
  logic           trailer;
  logic [7:0]     cur_byte;

  always_comb begin
    unique case (job_r.kind)
      hcfb_pkg::JOB_HDR:      last = (step_r == hcfb_pkg::STEP_CMD);
      hcfb_pkg::JOB_HDR_TRL:  last = (step_r == hcfb_pkg::STEP_POST);
      hcfb_pkg::JOB_DATA:     last = (step_r == 4'd0);
      hcfb_pkg::JOB_DATA_TRL: last = (step_r == 4'd2);
      default:                last = 1'b1;
    endcase
    trailer = (job_r.kind == hcfb_pkg::JOB_HDR_TRL) || (job_r.kind == hcfb_pkg::JOB_DATA_TRL);

    if ((job_r.kind == hcfb_pkg::JOB_DATA) || (job_r.kind == hcfb_pkg::JOB_DATA_TRL)) begin
      // payload byte, then dcs and postamble
      case (step_r)
        4'd0:    cur_byte = job_r.data_byte;
        4'd1:    cur_byte = job_r.dcs;
        default: cur_byte = hcfb_pkg::POSTAMBLE_BYTE;
      endcase
    end else begin
      case (step_r)
        hcfb_pkg::STEP_PRE:  cur_byte = hcfb_pkg::PREAMBLE_BYTE;
        hcfb_pkg::STEP_SCA:  cur_byte = hcfb_pkg::START_CODE_A;
        hcfb_pkg::STEP_SCB:  cur_byte = hcfb_pkg::START_CODE_B;
        hcfb_pkg::STEP_LEN:  cur_byte = job_r.len_byte;
        hcfb_pkg::STEP_LCS:  cur_byte = job_r.lcs;
        hcfb_pkg::STEP_TFI:  cur_byte = job_r.tfi;
        hcfb_pkg::STEP_CMD:  cur_byte = job_r.cmd;
        hcfb_pkg::STEP_DCS:  cur_byte = job_r.dcs;
        default:             cur_byte = hcfb_pkg::POSTAMBLE_BYTE;
      endcase
    end

    out_free  = !out_valid_r || !out_stall;
    advance   = job_valid_r && out_free;
    job_ready = !job_valid_r || (advance && last);

    out_valid_nxt = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_r);

    if (job_load) begin
      job_valid_nxt = 1'b1;
    end else if (advance && last) begin
      job_valid_nxt = 1'b0;
    end else begin
      job_valid_nxt = job_valid_r;
    end
    job_nxt = job_load ? job_in : job_r;

    if (advance) begin
      step_nxt = last ? 4'd0 : step_r + 4'd1;
    end else begin
      step_nxt = step_r;
    end

    stat.job_valid = job_valid_r;
    stat.last_step = last;
    stat.step      = step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (advance) begin
      byte_r      <= cur_byte;
      run_last_r  <= last;
      frame_end_r <= trailer && last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_run_last   = run_last_r;
  assign out_frame_end  = frame_end_r;

endmodule

### rtl/host_command_frame_builder.sv
// Host command frame builder: turns start and payload items into frame bytes.
// Input channel in_*: opcode 0 starts a frame (command, payload length),
// opcode 1 carries one payload byte. Output channel out_*: one frame byte per
// transfer, with run_last on the final byte of an item and frame_end on the
// postamble. cfg_wr_en/cfg_wr_data write the TFI byte (reset value D4h).
// The first byte of an item passes the job register, then the output register.
// A payload item gives one frame byte, the last payload item three (byte, DCS,
// postamble), a start seven, or nine with zero length.
// The output register passes one byte per cycle while out_stall is low: a
// single job register sits in front of it, so the next item is taken in the
// cycle the current job hands over its last byte. A payload item outside a
// frame is dropped at once when taken; it waits while in_stall is high.
// Reset clears the frame state, the job valid flag and the output valid, and
// loads the TFI default. A stall on out_* holds the byte in place, the job
// register fills and in_stall rises until the stall clears.
// depends on hcfb_pkg, hcfb_frame_ctrl, hcfb_byte_emit and the defines header
`include "host_command_frame_builder_defines.svh"

module host_command_frame_builder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_command_code,
  input  logic [7:0] in_payload_length,
  input  logic [7:0] in_payload_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic       out_run_last,
  output logic       out_frame_end
);

  logic                 in_accept;
  logic                 job_load;
  logic                 job_ready;
  hcfb_pkg::job_t       job;
  hcfb_pkg::ctrl_stat_t ctrl_stat;
  hcfb_pkg::emit_stat_t emit_stat;

  assign in_stall  = !job_ready;
  assign in_accept = in_valid && !in_stall;

  hcfb_frame_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_accept         (in_accept),
    .in_opcode         (in_opcode),
    .in_command_code   (in_command_code),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .job_load          (job_load),
    .job               (job),
    .stat              (ctrl_stat)
  );

  hcfb_byte_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_load       (job_load),
    .job_in         (job),
    .job_ready      (job_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_run_last   (out_run_last),
    .out_frame_end  (out_frame_end),
    .stat           (emit_stat)
  );

  `HCFB_ASSERT_NOW(a_open_has_bytes, clk, rst_n, ctrl_stat.frame_open, !ctrl_stat.rem_zero, "frame open with no payload bytes left")
  `HCFB_ASSERT_NOW(a_step_in_range, clk, rst_n, emit_stat.job_valid, emit_stat.step < hcfb_pkg::STEP_LIMIT, "byte step past end of frame")
  `HCFB_ASSERT_NOW(a_end_is_last, clk, rst_n, out_valid && out_frame_end, out_run_last, "postamble not marked as last byte of item")
  `HCFB_ASSERT_NEXT(a_job_held, clk, rst_n, job_load, emit_stat.job_valid && emit_stat.step == 4'd0, "loaded job not pending at first step")

endmodule

### tb/host_command_frame_builder_tb.sv
// self-checking testbench for host_command_frame_builder
// drives start and payload transfers with random idling, checks every frame byte
// depends on hcfb_pkg and the host_command_frame_builder rtl
module host_command_frame_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       run_last;
    logic       frame_end;
  } wire_byte_t;

  // one directed step: optional tfi write, then one input transfer
  typedef struct packed {
    logic        cfg_wr;
    logic [7:0]  cfg_val;
    logic        op;
    logic [7:0]  cmd;
    logic [7:0]  len;
    logic [7:0]  pbyte;
    logic        typed;
    logic [3:0]  n_typed;
    logic        closes;
    logic [71:0] typed_bytes;
  } dir_row_t;

  localparam int   DIR_ROWS = 21;
  localparam logic OP_S     = hcfb_pkg::OP_START;
  localparam logic OP_D     = hcfb_pkg::OP_DATA;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic       in_opcode;
  logic [7:0] in_command_code;
  logic [7:0] in_payload_length;
  logic [7:0] in_payload_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_frame_byte;
  logic       out_run_last;
  logic       out_frame_end;

  // predictor state
  logic [7:0] tfi_shadow;
  logic [7:0] payload_left;
  logic [7:0] dcs_sum;
  logic       frame_pending;

  wire_byte_t item_bytes[$];
  wire_byte_t wire_bytes_due[$];
  wire_byte_t due;

  int  errors;
  int  items_sent;
  int  items_dropped;
  int  bytes_seen;
  int  frames_closed;
  int  tfi_writes;
  bit  sink_idles;
  bit  long_hold_req;
  int  hold_left;

  dir_row_t dir_rows [DIR_ROWS];

  host_command_frame_builder u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_command_code   (in_command_code),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_byte    (out_frame_byte),
    .out_run_last      (out_run_last),
    .out_frame_end     (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("host_command_frame_builder_tb NOT OK");
    $finish;
  end

  task automatic close_frame();
    item_bytes.push_back('{8'h00 - dcs_sum, 1'b0, 1'b0});
    item_bytes.push_back('{hcfb_pkg::POSTAMBLE_BYTE, 1'b0, 1'b1});
    frame_pending = 1'b0;
    payload_left  = 8'd0;
  endtask

  // frame bytes caused by one accepted input transfer
  task automatic predict_frame_bytes(input logic op, input logic [7:0] cmd,
                                     input logic [7:0] len, input logic [7:0] pb);
    logic [7:0] total;
    item_bytes.delete();
    if (op == OP_S) begin
      total = len + 8'd2;
      item_bytes.push_back('{hcfb_pkg::PREAMBLE_BYTE, 1'b0, 1'b0});
      item_bytes.push_back('{hcfb_pkg::START_CODE_A, 1'b0, 1'b0});
      item_bytes.push_back('{hcfb_pkg::START_CODE_B, 1'b0, 1'b0});
      item_bytes.push_back('{total, 1'b0, 1'b0});
      item_bytes.push_back('{8'h00 - total, 1'b0, 1'b0});
      item_bytes.push_back('{tfi_shadow, 1'b0, 1'b0});
      item_bytes.push_back('{cmd, 1'b0, 1'b0});
      dcs_sum       = tfi_shadow + cmd;
      payload_left  = len;
      frame_pending = 1'b1;
      if (len == 8'd0) close_frame();
    end else if (frame_pending) begin
      item_bytes.push_back('{pb, 1'b0, 1'b0});
      dcs_sum      = dcs_sum + pb;
      payload_left = payload_left - 8'd1;
      if (payload_left == 8'd0) close_frame();
    end
    if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].run_last = 1'b1;
  endtask

  task automatic send_item(input logic op, input logic [7:0] cmd, input logic [7:0] len,
                           input logic [7:0] pb, input bit push_model);
    @(negedge clk);
    in_opcode         = op;
    in_command_code   = cmd;
    in_payload_length = len;
    in_payload_byte   = pb;
    in_valid          = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_D && !frame_pending) items_dropped++;
    else items_sent++;
    predict_frame_bytes(op, cmd, len, pb);
    if (push_model) foreach (item_bytes[k]) wire_bytes_due.push_back(item_bytes[k]);
  endtask

  task automatic sender_gap(input bit en);
    int g;
    if (en && $urandom_range(0, 5) == 0) begin
      g = $urandom_range(1, 12);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // tfi may only change once the block has gone quiet
  task automatic write_tfi(input logic [7:0] v);
    if (in_valid) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    while (wire_bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en  = 1'b0;
    tfi_shadow = v;
    tfi_writes++;
  endtask

  // mostly well-formed frames with random content, some cut short, some stray payload
  task automatic run_phase(input int target, input bit snd_gaps);
    int done;
    int len;
    int nbytes;
    done = 0;
    while (done < target) begin
      if (!frame_pending && $urandom_range(0, 9) == 0) begin
        sender_gap(snd_gaps);
        send_item(OP_D, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      end else begin
        if ($urandom_range(0, 11) == 0) len = $urandom_range(0, 255);
        else len = $urandom_range(0, 8);
        if (len > 16) nbytes = $urandom_range(0, 6);
        else if (len > 0 && $urandom_range(0, 7) == 0) nbytes = $urandom_range(0, len - 1);
        else nbytes = len;
        sender_gap(snd_gaps);
        send_item(OP_S, 8'($urandom), len[7:0], 8'($urandom), 1'b1);
        done++;
        repeat (nbytes) begin
          sender_gap(snd_gaps);
          send_item(OP_D, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
          done++;
        end
      end
    end
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold_left     = 150;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (sink_idles && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        hold_left = $urandom_range(0, 11);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      bytes_seen++;
      if (out_frame_end) frames_closed++;
      if (wire_bytes_due.size() == 0) begin
        $display("%0t: frame byte %02h with nothing expected", $time, out_frame_byte);
        errors++;
      end else begin
        due = wire_bytes_due.pop_front();
        if (out_frame_byte !== due.frame_byte) begin
          $display("%0t: frame_byte expected %02h got %02h", $time, due.frame_byte,
                   out_frame_byte);
          errors++;
        end
        if (out_run_last !== due.run_last) begin
          $display("%0t: run_last expected %b got %b", $time, due.run_last, out_run_last);
          errors++;
        end
        if (out_frame_end !== due.frame_end) begin
          $display("%0t: frame_end expected %b got %b", $time, due.frame_end, out_frame_end);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t r;
    logic     is_last;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 8'h00;
    in_valid          = 1'b0;
    in_opcode         = OP_S;
    in_command_code   = 8'h00;
    in_payload_length = 8'h00;
    in_payload_byte   = 8'h00;
    tfi_shadow        = hcfb_pkg::TFI_RESET;
    payload_left      = 8'd0;
    dcs_sum           = 8'd0;
    frame_pending     = 1'b0;
    errors            = 0;
    items_sent        = 0;
    items_dropped     = 0;
    bytes_seen        = 0;
    frames_closed     = 0;
    tfi_writes        = 0;
    sink_idles        = 1'b1;
    long_hold_req     = 1'b0;

    dir_rows = '{
      // stray payload after reset, then zero-length frame with default tfi
      '{1'b0, 8'h00, OP_D, 8'h00, 8'd0, 8'hAA, 1'b1, 4'd0, 1'b0, 72'h0},
      '{1'b0, 8'h00, OP_S, 8'h00, 8'd0, 8'h00, 1'b1, 4'd9, 1'b1, 72'h00_00_FF_02_FE_D4_00_2C_00},
      '{1'b0, 8'h00, OP_S, 8'hFF, 8'd253, 8'h00, 1'b1, 4'd7, 1'b0, 72'h00_00_FF_FF_01_D4_FF_00_00},
      '{1'b0, 8'h00, OP_D, 8'h00, 8'd0, 8'hFF, 1'b0, 4'd0, 1'b0, 72'h0},
      // lengths past 253 wrap LEN and LCS, and abandon the open frame
      '{1'b0, 8'h00, OP_S, 8'h4A, 8'd254, 8'h00, 1'b1, 4'd7, 1'b0, 72'h00_00_FF_00_00_D4_4A_00_00},
      '{1'b0, 8'h00, OP_D, 8'h00, 8'd0, 8'h33, 1'b0, 4'd0, 1'b0, 72'h0},
      '{1'b0, 8'h00, OP_S, 8'h4A, 8'd255, 8'h00, 1'b1, 4'd7, 1'b0, 72'h00_00_FF_01_FF_D4_4A_00_00},
      '{1'b0, 8'h00, OP_S, 8'h12, 8'd1, 8'h00, 1'b0, 4'd0, 1'b0, 72'h0},
      '{1'b0, 8'h00, OP_D, 8'h00, 8'd0, 8'h00, 1'b0, 4'd0, 1'b0, 72'h0},
      '{1'b0, 8'h00, OP_D, 8'h00, 8'd0, 8'h55, 1'b1, 4'd0, 1'b0, 72'h0},
      '{1'b0, 8'h00, OP_S, 8'h02, 8'd3, 8'h00, 1'b0, 4'd0, 1'b0, 72'h0},
      '{1'b0, 8'h00, OP_D, 8'h00, 8'd0, 8'h01, 1'b0, 4'd0, 1'b0, 72'h0},
      '{1'b0, 8'h00, OP_D, 8'h00, 8'd0, 8'hFE, 1'b0, 4'd0, 1'b0, 72'h0},
      '{1'b0, 8'h00, OP_D, 8'h00, 8'd0, 8'h80, 1'b0, 4'd0, 1'b0, 72'h0},
      '{1'b0, 8'h00, OP_S, 8'h00, 8'd2, 8'h00, 1'b0, 4'd0, 1'b0, 72'h0},
      '{1'b0, 8'h00, OP_D, 8'h00, 8'd0, 8'hFF, 1'b0, 4'd0, 1'b0, 72'h0},
      '{1'b0, 8'h00, OP_D, 8'h00, 8'd0, 8'h00, 1'b0, 4'd0, 1'b0, 72'h0},
      // tfi extremes
      '{1'b1, 8'h00, OP_S, 8'h00, 8'd0, 8'h00, 1'b1, 4'd9, 1'b1, 72'h00_00_FF_02_FE_00_00_00_00},
      '{1'b1, 8'hFF, OP_S, 8'hFF, 8'd0, 8'h00, 1'b1, 4'd9, 1'b1, 72'h00_00_FF_02_FE_FF_FF_02_00},
      '{1'b0, 8'h00, OP_S, 8'h80, 8'd1, 8'h00, 1'b0, 4'd0, 1'b0, 72'h0},
      '{1'b0, 8'h00, OP_D, 8'h00, 8'd0, 8'h7F, 1'b0, 4'd0, 1'b0, 72'h0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      r = dir_rows[i];
      if (r.cfg_wr) write_tfi(r.cfg_val);
      sender_gap(1'b1);
      send_item(r.op, r.cmd, r.len, r.pbyte, !r.typed);
      for (int k = 0; k < int'(r.n_typed); k++) begin
        is_last = (k == int'(r.n_typed) - 1);
        wire_bytes_due.push_back('{r.typed_bytes[71 - 8 * k -: 8], is_last,
                                   is_last & r.closes});
      end
    end

    // long receiver hold while the sender keeps offering back to back
    write_tfi(8'($urandom));
    long_hold_req = 1'b1;
    run_phase(96, 1'b0);

    write_tfi(8'($urandom));
    run_phase(96, 1'b1);

    // idle-free tail
    write_tfi(8'($urandom));
    sink_idles = 1'b0;
    run_phase(96, 1'b0);

    @(negedge clk);
    in_valid = 1'b0;
    while (wire_bytes_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d frame transfers and %0d stray payload transfers, %0d frame bytes",
             items_sent, items_dropped, bytes_seen);
    $display("%0d frames closed with checksum, %0d tfi settings incl. 00 and FF",
             frames_closed, tfi_writes);
    if (errors == 0) begin
      $display("host_command_frame_builder_tb OK");
    end else begin
      $display("host_command_frame_builder_tb NOT OK");
    end
    $finish;
  end

endmodule
